>>> rtl/pipeo_pkg.sv
// Shared types and constants for the even-odd point-in-path core.
package pipeo_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;

    localparam int EQ_DEPTH = 4;
    localparam int EQ_AW    = $clog2(EQ_DEPTH);

    localparam int CFG_IDX_WIDTH = 2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_QUERY_X = CFG_IDX_WIDTH'(0);
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_QUERY_Y = CFG_IDX_WIDTH'(1);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;

    typedef enum logic [1:0] {
        OP_MOVE   = 2'd0,
        OP_LINE   = 2'd1,
        OP_CLOSE  = 2'd2,
        OP_FINISH = 2'd3
    } op_t;

    typedef struct packed {
        logic   fin;
        coord_t x1;
        coord_t y1;
        coord_t x2;
        coord_t y2;
    } edge_rec_t;

    typedef struct packed {
        coord_t qx;
        coord_t qy;
    } query_t;

endpackage

>>> rtl/pipeo_front.sv
// Front end: accepts path commands, tracks vertices and emits edge records.
module pipeo_front
    import pipeo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        q_full,
    input  logic [1:0]  operation,
    input  logic [31:0] vertex_x,
    input  logic [31:0] vertex_y,
    output logic        q_push,
    output edge_rec_t   q_rec
);

    coord_t prev_x_reg, prev_x_next;
    coord_t prev_y_reg, prev_y_next;
    coord_t start_x_reg, start_x_next;
    coord_t start_y_reg, start_y_next;
    logic   have_prev_reg, have_prev_next;
    coord_t vx;
    coord_t vy;
    logic   accept;

    assign vx     = $signed(vertex_x[COORD_WIDTH-1:0]);
    assign vy     = $signed(vertex_y[COORD_WIDTH-1:0]);
    assign accept = push && !q_full;

    always_comb
    begin
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        start_x_next   = start_x_reg;
        start_y_next   = start_y_reg;
        have_prev_next = have_prev_reg;
        q_push         = 1'b0;
        q_rec.fin      = 1'b0;
        q_rec.x1       = prev_x_reg;
        q_rec.y1       = prev_y_reg;
        q_rec.x2       = vx;
        q_rec.y2       = vy;
        if (accept)
        begin
            case (op_t'(operation))
                OP_MOVE:
                begin
                    start_x_next   = vx;
                    start_y_next   = vy;
                    prev_x_next    = vx;
                    prev_y_next    = vy;
                    have_prev_next = 1'b1;
                end
                OP_LINE:
                begin
                    q_push         = have_prev_reg;
                    prev_x_next    = vx;
                    prev_y_next    = vy;
                    have_prev_next = 1'b1;
                end
                OP_CLOSE:
                begin
                    q_rec.x2 = start_x_reg;
                    q_rec.y2 = start_y_reg;
                    if (have_prev_reg)
                    begin
                        q_push      = 1'b1;
                        prev_x_next = start_x_reg;
                        prev_y_next = start_y_reg;
                    end
                end
                OP_FINISH:
                begin
                    q_push         = 1'b1;
                    q_rec.fin      = 1'b1;
                    prev_x_next    = '0;
                    prev_y_next    = '0;
                    start_x_next   = '0;
                    start_y_next   = '0;
                    have_prev_next = 1'b0;
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            have_prev_reg <= 1'b0;
        end
        else
        begin
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            start_x_reg   <= start_x_next;
            start_y_reg   <= start_y_next;
            have_prev_reg <= have_prev_next;
        end
    end

endmodule

>>> rtl/pipeo_edge_q.sv
// Short queue of edge and finish records between front and back.
module pipeo_edge_q
    import pipeo_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  edge_rec_t push_rec,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output edge_rec_t head_rec
);

    edge_rec_t          mem_reg [EQ_DEPTH];
    logic [EQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [EQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [EQ_AW:0]     count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full       = (count_reg == (EQ_AW+1)'(EQ_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_rec   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_rec;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (EQ_AW+1)'(EQ_DEPTH))
        else $error("edge queue count out of range");

    a_pop_moves_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head_valid) |=> (rd_ptr_reg == $past(rd_ptr_reg) + 1'b1))
        else $error("edge queue read pointer did not advance");
`endif

endmodule

>>> rtl/pipeo_back.sv
// Back end: crossing test per edge, parity tracking and result queue.
module pipeo_back
    import pipeo_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  query_t    query,
    input  logic      head_valid,
    input  edge_rec_t head_rec,
    output logic      q_pop,
    output logic      empty,
    input  logic      pop,
    output logic      inside_res
);

    diff_t dxq;
    diff_t dy;
    diff_t eyq;
    diff_t dx;
    logic  straddle;

    logic  s1_valid_reg;
    logic  s1_fin_reg;
    logic  s1_straddle_reg;
    logic  s1_dir_reg;
    prod_t s1_l_reg;
    prod_t s1_r_reg;

    logic  parity_reg, parity_next;
    logic  crosses;
    logic  stall;

    logic       res_mem_reg [2];
    logic       res_wr_reg;
    logic       res_rd_reg;
    logic [1:0] res_count_reg, res_count_next;
    logic       res_full;
    logic       res_push;
    logic       res_pop;

    assign dxq = {query.qx[COORD_WIDTH-1], query.qx}
               - {head_rec.x1[COORD_WIDTH-1], head_rec.x1};
    assign dy  = {head_rec.y2[COORD_WIDTH-1], head_rec.y2}
               - {head_rec.y1[COORD_WIDTH-1], head_rec.y1};
    assign eyq = {query.qy[COORD_WIDTH-1], query.qy}
               - {head_rec.y1[COORD_WIDTH-1], head_rec.y1};
    assign dx  = {head_rec.x2[COORD_WIDTH-1], head_rec.x2}
               - {head_rec.x1[COORD_WIDTH-1], head_rec.x1};
    assign straddle = (head_rec.y1 > query.qy) != (head_rec.y2 > query.qy);

    assign res_full = (res_count_reg == 2'd2);
    assign stall    = s1_valid_reg && s1_fin_reg && res_full;
    assign q_pop    = head_valid && !stall;
    assign res_push = s1_valid_reg && s1_fin_reg && !res_full;
    assign empty    = (res_count_reg == 2'd0);
    assign res_pop  = pop && !empty;
    assign inside_res = res_mem_reg[res_rd_reg];

    assign crosses = s1_straddle_reg &&
                     (s1_dir_reg ? (s1_l_reg < s1_r_reg) : (s1_r_reg < s1_l_reg));

    always_comb
    begin
        parity_next = parity_reg;
        if (s1_valid_reg && !stall)
        begin
            if (s1_fin_reg)
                parity_next = 1'b0;
            else if (crosses)
                parity_next = !parity_reg;
        end
    end

    always_comb
    begin
        res_count_next = res_count_reg;
        if (res_push && !res_pop)
            res_count_next = res_count_reg + 1'b1;
        else if (!res_push && res_pop)
            res_count_next = res_count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            parity_reg    <= 1'b0;
            res_wr_reg    <= 1'b0;
            res_rd_reg    <= 1'b0;
            res_count_reg <= 2'd0;
        end
        else
        begin
            if (!stall)
                s1_valid_reg <= head_valid;
            parity_reg    <= parity_next;
            res_count_reg <= res_count_next;
            if (res_push)
                res_wr_reg <= !res_wr_reg;
            if (res_pop)
                res_rd_reg <= !res_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_fin_reg      <= head_rec.fin;
            s1_straddle_reg <= straddle;
            s1_dir_reg      <= head_rec.y2 > head_rec.y1;
            s1_l_reg        <= PROD_WIDTH'(dxq) * PROD_WIDTH'(dy);
            s1_r_reg        <= PROD_WIDTH'(eyq) * PROD_WIDTH'(dx);
        end
        if (res_push)
            res_mem_reg[res_wr_reg] <= parity_reg;
    end

`ifndef ASSERT_OFF
    a_res_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_count_reg <= 2'd2)
        else $error("result queue count out of range");

    a_stall_holds_finish: assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> (s1_valid_reg && s1_fin_reg))
        else $error("finish record lost during stall");

    a_finish_clears_parity: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> !parity_reg)
        else $error("parity not cleared after finish");
`endif

endmodule

>>> rtl/point_in_path_even_odd_core.sv
// Top level of the even-odd point-in-path core: query registers and pipeline.
//
// Usage:
//   Configuration: write query_x (index 0) and query_y (index 1) through
//   cfg_valid/cfg_ready/cfg_index/cfg_data while the core is idle. cfg_ready
//   is always high; other indexes are ignored.
//   Input: a transaction is taken when push is high and full is low. Each
//   carries operation (move, line, close, finish) and a vertex.
//   Output: while empty is low, inside_res holds the oldest result; pop
//   takes it. Only finish produces a result.
// Throughput: one command per cycle while full is low; the edge queue and
//   the two-stage crossing unit each take one record a cycle unless stalled.
// Finish path: a finish waits in the four-entry queue until earlier edges
//   drain, is registered in the crossing stage, then enters the result queue.
// Stall: if the result side is not popped, the two-entry result queue fills,
//   the crossing unit holds, the edge queue fills and full rises.
// Reset: clears path state, parity, queues and both query registers.
module point_in_path_even_odd_core
    import pipeo_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [1:0]               operation,
    input  logic [31:0]              vertex_x,
    input  logic [31:0]              vertex_y,
    output logic                     empty,
    input  logic                     pop,
    output logic                     inside_res,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [31:0]              cfg_data
);

    query_t    query_reg;
    logic      q_push;
    edge_rec_t q_rec;
    logic      q_full;
    logic      q_pop;
    logic      head_valid;
    edge_rec_t head_rec;

    assign cfg_ready = 1'b1;
    assign full      = q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_QUERY_X)
                query_reg.qx <= $signed(cfg_data[COORD_WIDTH-1:0]);
            else if (cfg_index == CFG_QUERY_Y)
                query_reg.qy <= $signed(cfg_data[COORD_WIDTH-1:0]);
        end
    end

    pipeo_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .q_full    (q_full),
        .operation (operation),
        .vertex_x  (vertex_x),
        .vertex_y  (vertex_y),
        .q_push    (q_push),
        .q_rec     (q_rec)
    );

    pipeo_edge_q u_edge_q (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_rec   (q_rec),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    pipeo_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .query      (query_reg),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .inside_res (inside_res)
    );

endmodule
